### rtl/pip_pkg.sv
// shared types and constants for the point-in-polygon block
`default_nettype none

package pip_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int POINT_W = 2 * COORD_W;

   // parameter defaults
   localparam int MAX_VERTICES_DEF = 64;
   localparam int RAY_END_X_DEF    = 10000;

   // item kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // orientation codes
   localparam logic [1:0] TURN_COLL = 2'd0;
   localparam logic [1:0] TURN_CW   = 2'd1;
   localparam logic [1:0] TURN_CCW  = 2'd2;

   // one vertex as stored: y in the upper half, x in the lower half
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // edge handed to the edge tester
   typedef struct packed {
      logic      valid;
      logic      last;
      point_type a;
      point_type b;
   } edge_req_type;

   // verdict for one edge
   typedef struct packed {
      logic valid;
      logic last;
      logic meet;
      logic coll;
      logic on_edge;
   } edge_rsp_type;

endpackage

`default_nettype wire

### rtl/point_in_polygon_test.sv
// top level of the ray-casting point-in-polygon block
// vertex write: no result; next item may start in the following cycle
// query with n = min(vertex_count, MAX_VERTICES) >= 3: result strobe after the vertex walk,
// which does one vertex ram read per cycle and feeds a 3-stage edge tester
// query with fewer than three vertices: result (outside) in the next cycle
// synchronous reset clears control and vertex_count; vertex ram holds no reset value
// the receiver cannot stall: each result is on rsp_ ports for exactly one cycle
`default_nettype none

module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int RAY_END_X    = RAY_END_X_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_kind,
   input  wire logic [INDEX_W-1:0]        req_vertex_index,
   input  wire logic signed [COORD_W-1:0] req_coord_x,
   input  wire logic signed [COORD_W-1:0] req_coord_y,
   output logic                           rsp_valid,
   output logic                           rsp_inside_res,
   input  wire logic                      csr_wr_en,
   input  wire logic [COUNT_W-1:0]        csr_wr_data
);

   localparam int AW = $clog2(MAX_VERTICES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] vcount_ff;
   point_type          pt_ff, pt_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [AW-1:0]      last_idx_ff, last_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_first_ff, rd_first_in;
   logic               rd_last_ff, rd_last_in;
   logic               wrap_ff, wrap_in;
   point_type          v0_ff, prev_ff;
   logic               found_ff, found_in;
   logic               ans_ff, ans_in;
   logic               parity_ff, parity_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_inside_ff, rsp_inside_in;

   logic               accept;
   logic [31:0]        cnt_wide, n_wide, slot_wide;
   logic               few;
   logic               slot_ok;

   logic               ram_wr_en;
   logic               ram_rd_en;
   point_type          ram_wr_data;
   logic [POINT_W-1:0] ram_rd_raw;
   point_type          ram_rd_data;

   edge_req_type       edge_req;
   edge_rsp_type       edge_rsp;

   assign busy           = (state_ff != ST_IDLE);
   assign accept         = start && !busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // vertex count in use, clamped to the ram depth
   always_comb begin
      cnt_wide  = 32'(vcount_ff);
      n_wide    = (cnt_wide > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : cnt_wide;
      few       = (n_wide < 32'd3);
      slot_wide = 32'(req_vertex_index);
      slot_ok   = (slot_wide < 32'(MAX_VERTICES));
   end

   // vertex ram write data and read data view
   always_comb begin
      ram_wr_data.x = req_coord_x;
      ram_wr_data.y = req_coord_y;
      ram_rd_data   = point_type'(ram_rd_raw);
   end

   // vertex store
   pip_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_wide[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_raw)
   );

   // edge assembly: consecutive vertices, then the closing edge
   always_comb begin
      wrap_in        = rd_vld_ff && rd_last_ff;
      edge_req.valid = (rd_vld_ff && !rd_first_ff) || wrap_ff;
      edge_req.last  = wrap_ff;
      edge_req.a     = prev_ff;
      edge_req.b     = wrap_ff ? v0_ff : ram_rd_data;
   end

   pip_edge #(
      .RAY_END_X (RAY_END_X)
   ) u_edge (
      .clock    (clock),
      .reset    (reset),
      .edge_req (edge_req),
      .pt       (pt_ff),
      .edge_rsp (edge_rsp)
   );

   // sequencer and crossing count
   always_comb begin
      state_in      = state_ff;
      pt_in         = pt_ff;
      rd_idx_in     = rd_idx_ff;
      last_idx_in   = last_idx_ff;
      rd_vld_in     = 1'b0;
      rd_first_in   = rd_first_ff;
      rd_last_in    = rd_last_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      found_in      = found_ff;
      ans_in        = ans_ff;
      parity_in     = parity_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = rsp_inside_ff;

      // first collinear crossing settles the answer, later edges are ignored
      if (edge_rsp.valid && !found_ff && edge_rsp.meet) begin
         if (edge_rsp.coll) begin
            found_in = 1'b1;
            ans_in   = edge_rsp.on_edge;
         end else begin
            parity_in = !parity_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_QUERY) begin
                  pt_in.x   = req_coord_x;
                  pt_in.y   = req_coord_y;
                  found_in  = 1'b0;
                  parity_in = 1'b0;
                  if (few) begin
                     rsp_valid_in  = 1'b1;
                     rsp_inside_in = 1'b0;
                  end else begin
                     rd_idx_in   = '0;
                     last_idx_in = AW'(n_wide - 32'd1);
                     state_in    = ST_WALK;
                  end
               end else begin
                  ram_wr_en = slot_ok;
               end
            end
         end
         ST_WALK: begin
            ram_rd_en   = 1'b1;
            rd_vld_in   = 1'b1;
            rd_first_in = (rd_idx_ff == '0);
            rd_last_in  = (rd_idx_ff == last_idx_ff);
            if (rd_idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (edge_rsp.valid && edge_rsp.last) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = found_in ? ans_in : parity_in;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pt_ff         <= pt_in;
      rd_idx_ff     <= rd_idx_in;
      last_idx_ff   <= last_idx_in;
      rd_first_ff   <= rd_first_in;
      rd_last_ff    <= rd_last_in;
      found_ff      <= found_in;
      ans_ff        <= ans_in;
      parity_ff     <= parity_in;
      rsp_inside_ff <= rsp_inside_in;
      if (rd_vld_ff) begin
         prev_ff <= ram_rd_data;
         if (rd_first_ff) begin
            v0_ff <= ram_rd_data;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/pip_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/pip_edge.sv
// pipelined edge-against-ray tester: orientation tests and bounding boxes
`default_nettype none

module pip_edge
   import pip_pkg::*;
#(
   parameter int RAY_END_X = RAY_END_X_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire edge_req_type edge_req,
   input  wire point_type    pt,
   output edge_rsp_type      edge_rsp
);

   localparam int NT = 5;   // orientation tests per edge
   localparam int NB = 4;   // bounding-box tests per edge
   localparam logic signed [COORD_W-1:0] FAR_X = COORD_W'(RAY_END_X);

   // q within the box spanned by a and c
   function automatic logic in_box(point_type a, point_type q, point_type c);
      logic signed [COORD_W-1:0] hx, lx, hy, ly;
      hx = ($signed(a.x) > $signed(c.x)) ? a.x : c.x;
      lx = ($signed(a.x) > $signed(c.x)) ? c.x : a.x;
      hy = ($signed(a.y) > $signed(c.y)) ? a.y : c.y;
      ly = ($signed(a.y) > $signed(c.y)) ? c.y : a.y;
      return ($signed(q.x) <= hx) && ($signed(q.x) >= lx) &&
             ($signed(q.y) <= hy) && ($signed(q.y) >= ly);
   endfunction

   // sign-extended difference of two coordinates
   function automatic logic signed [COORD_W:0] diff(logic [COORD_W-1:0] u,
                                                     logic [COORD_W-1:0] v);
      logic signed [COORD_W:0] su, sv;
      su = $signed({u[COORD_W-1], u});
      sv = $signed({v[COORD_W-1], v});
      return su - sv;
   endfunction

   point_type far_pt;
   point_type ta [NT];
   point_type tb [NT];
   point_type tc [NT];
   logic      box [NB];

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s2_valid_ff, s3_valid_ff;
   logic                            s1_last_ff, s2_last_ff, s3_last_ff;
   logic signed [COORD_W:0]         s1_d_ff [NT][4];
   logic signed [COORD_W:0]         s1_d_in [NT][4];
   logic signed [2*COORD_W+1:0]     s2_p_ff [NT][2];
   logic [1:0]                      s3_turn_ff [NT];
   logic [1:0]                      s3_turn_in [NT];
   logic signed [2*COORD_W+2:0]     det [NT];
   logic                            s1_box_ff [NB];
   logic                            s2_box_ff [NB];
   logic                            s3_box_ff [NB];

   // test points of the five orientation tests, box tests and first-stage differences
   always_comb begin
      far_pt.x = FAR_X;
      far_pt.y = pt.y;
      ta[0] = edge_req.a; tb[0] = edge_req.b; tc[0] = pt;
      ta[1] = edge_req.a; tb[1] = edge_req.b; tc[1] = far_pt;
      ta[2] = pt;         tb[2] = far_pt;     tc[2] = edge_req.a;
      ta[3] = pt;         tb[3] = far_pt;     tc[3] = edge_req.b;
      ta[4] = edge_req.a; tb[4] = pt;         tc[4] = edge_req.b;
      box[0] = in_box(edge_req.a, pt, edge_req.b);
      box[1] = in_box(edge_req.a, far_pt, edge_req.b);
      box[2] = in_box(pt, edge_req.a, far_pt);
      box[3] = in_box(pt, edge_req.b, far_pt);
      for (int k = 0; k < NT; k++) begin
         s1_d_in[k][0] = diff(tb[k].y, ta[k].y);
         s1_d_in[k][1] = diff(tc[k].x, tb[k].x);
         s1_d_in[k][2] = diff(tb[k].x, ta[k].x);
         s1_d_in[k][3] = diff(tc[k].y, tb[k].y);
      end
      s1_valid_in = edge_req.valid;
   end

   // cross-product sign
   always_comb begin
      for (int k = 0; k < NT; k++) begin
         det[k] = (2*COORD_W+3)'(s2_p_ff[k][0]) - (2*COORD_W+3)'(s2_p_ff[k][1]);
         if (det[k] == '0) begin
            s3_turn_in[k] = TURN_COLL;
         end else if (det[k] > 0) begin
            s3_turn_in[k] = TURN_CW;
         end else begin
            s3_turn_in[k] = TURN_CCW;
         end
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // pipeline payload: differences, products, orientation codes
   always_ff @(posedge clock) begin
      s1_last_ff <= edge_req.last;
      s2_last_ff <= s1_last_ff;
      s3_last_ff <= s2_last_ff;
      for (int k = 0; k < NT; k++) begin
         for (int j = 0; j < 4; j++) begin
            s1_d_ff[k][j] <= s1_d_in[k][j];
         end
         s2_p_ff[k][0] <= s1_d_ff[k][0] * s1_d_ff[k][1];
         s2_p_ff[k][1] <= s1_d_ff[k][2] * s1_d_ff[k][3];
         s3_turn_ff[k] <= s3_turn_in[k];
      end
      for (int k = 0; k < NB; k++) begin
         s1_box_ff[k] <= box[k];
         s2_box_ff[k] <= s1_box_ff[k];
         s3_box_ff[k] <= s2_box_ff[k];
      end
   end

   // segment test verdict
   always_comb begin
      edge_rsp.valid   = s3_valid_ff;
      edge_rsp.last    = s3_last_ff;
      edge_rsp.meet    = ((s3_turn_ff[0] != s3_turn_ff[1]) &&
                          (s3_turn_ff[2] != s3_turn_ff[3])) ||
                         ((s3_turn_ff[0] == TURN_COLL) && s3_box_ff[0]) ||
                         ((s3_turn_ff[1] == TURN_COLL) && s3_box_ff[1]) ||
                         ((s3_turn_ff[2] == TURN_COLL) && s3_box_ff[2]) ||
                         ((s3_turn_ff[3] == TURN_COLL) && s3_box_ff[3]);
      edge_rsp.coll    = (s3_turn_ff[4] == TURN_COLL);
      edge_rsp.on_edge = s3_box_ff[0];
   end

endmodule

`default_nettype wire

### rtl/pip_checker.sv
// port-level checks for the point-in-polygon block, bound to the top level
`default_nettype none

module pip_checker
   import pip_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_kind,
   input wire logic rsp_valid
);

   // a result strobe lasts one cycle unless a fresh query answers at once
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid || $past(start && !busy && (req_kind == KIND_QUERY))))
      else $error("result strobe held for more than one cycle");

   // a vertex write transfer produces no result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_VERTEX)) |=> !rsp_valid)
      else $error("result after a vertex write");

   // a query transfer either starts a walk or answers at once
   a_query_runs: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_QUERY)) |=> (busy || rsp_valid))
      else $error("query transfer neither busy nor answered");

   // a walk ends only with a result
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result");

   // no result while a walk is still running
   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the ray-casting point-in-polygon block
module tb
   import pip_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_GOAL    = 1450;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_CYCLES = MAX_VERTICES_DEF + 16;
   localparam int STALL_LIMIT  = 2000;
   localparam int RESET_CYCLES = 11;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   // one line of the directed table; verdict is used only where known is set
   typedef struct packed {
      row_op_type                op;
      logic                      kind;
      logic [INDEX_W-1:0]        slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COUNT_W-1:0]        count;
      logic                      known;
      logic                      verdict;
   } stim_row_type;

   typedef struct {
      longint x;
      longint y;
   } coord_pair_type;

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      start            = 1'b0;
   logic                      busy;
   logic                      req_kind         = KIND_VERTEX;
   logic [INDEX_W-1:0]        req_vertex_index = '0;
   logic signed [COORD_W-1:0] req_coord_x      = '0;
   logic signed [COORD_W-1:0] req_coord_y      = '0;
   logic                      rsp_valid;
   logic                      rsp_inside_res;
   logic                      csr_wr_en        = 1'b0;
   logic [COUNT_W-1:0]        csr_wr_data      = '0;

   // predictor state: polygon as the block should hold it
   point_type          poly_mem [MAX_VERTICES_DEF];
   logic [COUNT_W-1:0] poly_count = '0;

   bit pending_verdicts [$];
   int err_count    = 0;
   int item_total   = 0;
   int idle_pct     = 20;
   int stall_cycles = 0;

   // area that the current phase draws its coordinates from
   int area_cx   = 0;
   int area_cy   = 0;
   int area_rad  = 8;
   bit area_full = 1'b0;

   // directed table: extremes, both kinds, each corner case of the scheme
   // 16'sh8000 is -32768 and 16'sh7FFF is 32767
   stim_row_type directed_rows [24] = '{
      // nothing configured yet
      '{ROW_CSR,  KIND_VERTEX, 6'd0,  16'sd0,     16'sd0,     7'd0, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sd0,     16'sd0,     7'd0, 1'b1, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd63, 16'sh8000,  16'sh7FFF,  7'd0, 1'b1, 1'b0},
      // square of side 200 round the origin
      '{ROW_ITEM, KIND_VERTEX, 6'd0,  -16'sd100,  -16'sd100,  7'd0, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_VERTEX, 6'd1,  16'sd100,   -16'sd100,  7'd0, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_VERTEX, 6'd2,  16'sd100,   16'sd100,   7'd0, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_VERTEX, 6'd3,  -16'sd100,  16'sd100,   7'd0, 1'b0, 1'b0},
      // too few vertices
      '{ROW_CSR,  KIND_VERTEX, 6'd0,  16'sd0,     16'sd0,     7'd2, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sd0,     16'sd0,     7'd0, 1'b1, 1'b0},
      // inside, on an edge, on a vertex, outside, right of the ray end
      '{ROW_CSR,  KIND_VERTEX, 6'd0,  16'sd0,     16'sd0,     7'd4, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sd0,     16'sd0,     7'd0, 1'b1, 1'b1},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sd100,   16'sd0,     7'd0, 1'b1, 1'b1},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  -16'sd100,  -16'sd100,  7'd0, 1'b1, 1'b1},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sd200,   16'sd0,     7'd0, 1'b1, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sd20000, 16'sd0,     7'd0, 1'b1, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  -16'sd100,  16'sd50,    7'd0, 1'b0, 1'b0},
      // triangle on the corners of the coordinate range
      '{ROW_ITEM, KIND_VERTEX, 6'd0,  16'sh8000,  16'sh8000,  7'd0, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_VERTEX, 6'd1,  16'sh7FFF,  16'sh8000,  7'd0, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_VERTEX, 6'd2,  16'sh7FFF,  16'sh7FFF,  7'd0, 1'b0, 1'b0},
      '{ROW_CSR,  KIND_VERTEX, 6'd0,  16'sd0,     16'sd0,     7'd3, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sh7FFF,  16'sh7FFF,  7'd0, 1'b1, 1'b1},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sd0,     16'sd0,     7'd0, 1'b0, 1'b0},
      '{ROW_ITEM, KIND_QUERY,  6'd0,  16'sh8000,  16'sh7FFF,  7'd0, 1'b0, 1'b0},
      // highest slot, outside the polygon in use
      '{ROW_ITEM, KIND_VERTEX, 6'd63, 16'sh7FFF,  16'sh8000,  7'd0, 1'b0, 1'b0}
   };

   point_in_polygon_test #(
      .MAX_VERTICES (MAX_VERTICES_DEF),
      .RAY_END_X    (RAY_END_X_DEF)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // predictor: exact orientation and bounding-box tests
   function automatic coord_pair_type widen(input point_type p);
      coord_pair_type w;
      w.x = p.x;
      w.y = p.y;
      return w;
   endfunction

   function automatic logic [1:0] orientation(input coord_pair_type a, b, c);
      longint v;
      v = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
      if (v == 0) return TURN_COLL;
      return (v > 0) ? TURN_CW : TURN_CCW;
   endfunction

   // q within the box spanned by a and c
   function automatic bit within_box(input coord_pair_type a, q, c);
      return (q.x <= a.x || q.x <= c.x) && (q.x >= a.x || q.x >= c.x) &&
             (q.y <= a.y || q.y <= c.y) && (q.y >= a.y || q.y >= c.y);
   endfunction

   function automatic bit edges_cross(input coord_pair_type a1, b1, a2, b2);
      logic [1:0] t1, t2, t3, t4;
      t1 = orientation(a1, b1, a2);
      t2 = orientation(a1, b1, b2);
      t3 = orientation(a2, b2, a1);
      t4 = orientation(a2, b2, b1);
      if (t1 != t2 && t3 != t4) return 1'b1;
      if (t1 == TURN_COLL && within_box(a1, a2, b1)) return 1'b1;
      if (t2 == TURN_COLL && within_box(a1, b2, b1)) return 1'b1;
      if (t3 == TURN_COLL && within_box(a2, a1, b2)) return 1'b1;
      if (t4 == TURN_COLL && within_box(a2, b1, b2)) return 1'b1;
      return 1'b0;
   endfunction

   // ray from the point to the ray end, odd crossing count means inside
   function automatic bit predict_inside(input point_type q);
      int             n;
      int             hits;
      coord_pair_type p, ray_end, a, b;
      n = (poly_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : poly_count;
      if (n < 3) return 1'b0;
      p = widen(q);
      ray_end.x = RAY_END_X_DEF;
      ray_end.y = p.y;
      hits = 0;
      for (int i = 0; i < n; i++) begin
         a = widen(poly_mem[i]);
         b = widen(poly_mem[(i + 1 == n) ? 0 : i + 1]);
         if (edges_cross(a, b, p, ray_end)) begin
            // an edge collinear with the point settles the answer at once
            if (orientation(a, p, b) == TURN_COLL) return within_box(a, p, b);
            hits++;
         end
      end
      return hits[0];
   endfunction

   // stimulus shaping
   function automatic logic signed [COORD_W-1:0] area_coord(input int centre);
      int v;
      if (area_full) return COORD_W'($urandom);
      v = centre + int'($urandom_range(2 * area_rad)) - area_rad;
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return COORD_W'(v);
   endfunction

   // query point: near the polygon, on vertices, on edge midpoints, level with vertices, random or beyond the ray end
   function automatic point_type query_point(input int drawn);
      point_type p, a, b;
      int        sel, k;
      sel = $urandom_range(99);
      p.x = area_coord(area_cx);
      p.y = area_coord(area_cy);
      if (drawn > 0) begin
         k = $urandom_range(drawn - 1);
         a = poly_mem[k];
         b = poly_mem[(k + 1) % drawn];
         if (sel >= 35 && sel < 55) begin
            p = a;
         end else if (sel >= 55 && sel < 75) begin
            p.x = COORD_W'((int'(a.x) + int'(b.x)) >>> 1);
            p.y = COORD_W'((int'(a.y) + int'(b.y)) >>> 1);
         end else if (sel >= 75 && sel < 85) begin
            p.y = a.y;
         end
      end
      if (sel >= 85 && sel < 93) begin
         p.x = COORD_W'($urandom);
         p.y = COORD_W'($urandom);
      end else if (sel >= 93) begin
         p.x = COORD_W'($urandom_range(32767, RAY_END_X_DEF + 1));
      end
      return p;
   endfunction

   // one input transfer, with an optional idle burst before it
   task automatic send_item(input logic kind, input logic [INDEX_W-1:0] slot,
                            input logic signed [COORD_W-1:0] x, y,
                            input bit known, verdict);
      point_type pt;
      if (item_total < ITEM_GOAL - QUIET_TAIL && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_vertex_index <= slot;
      req_coord_x      <= x;
      req_coord_y      <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      pt.x = x;
      pt.y = y;
      if (kind == KIND_VERTEX) poly_mem[slot] = pt;
      else pending_verdicts.push_back(known ? verdict : predict_inside(pt));
      item_total++;
   endtask

   // register write only once the block has gone quiet
   task automatic set_vertex_count(input logic [COUNT_W-1:0] value);
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      poly_count = value;
   endtask

   // result checking against the oldest expected verdict
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("inside_res: expected none, got %0b", rsp_inside_res);
            err_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_inside_res !== want) begin
               $error("inside_res: expected %0b, got %0b", want, rsp_inside_res);
               err_count++;
            end
         end
      end
   end

   // cycles without any transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // main sequence
   initial begin
      int        n_next, m, nq, pick, phase_no;
      point_type pt;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].op == ROW_CSR) begin
            set_vertex_count(directed_rows[r].count);
         end else begin
            send_item(directed_rows[r].kind, directed_rows[r].slot, directed_rows[r].x,
                      directed_rows[r].y, directed_rows[r].known, directed_rows[r].verdict);
         end
      end

      // random phases: write a polygon, switch the count, then query it
      phase_no = 0;
      while (item_total < ITEM_GOAL) begin
         pick = $urandom_range(99);
         if (phase_no == 0) n_next = 127;
         else if (phase_no == 1) n_next = MAX_VERTICES_DEF;
         else if (pick < 5) n_next = $urandom_range(2, 0);
         else if (pick < 65) n_next = $urandom_range(8, 3);
         else if (pick < 88) n_next = $urandom_range(MAX_VERTICES_DEF - 1, 9);
         else if (pick < 94) n_next = MAX_VERTICES_DEF;
         else n_next = $urandom_range(127, MAX_VERTICES_DEF + 1);
         m = (n_next > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : n_next;

         // tight areas give collinear and on-edge cases, wide ones the full range
         area_full = 1'b0;
         area_cx   = int'($urandom_range(60000)) - 30000;
         area_cy   = int'($urandom_range(60000)) - 30000;
         case ($urandom_range(3))
            0: begin
               area_rad = 6;
            end
            1: begin
               area_rad = 300;
            end
            2: begin
               area_rad = 15;
               area_cx  = RAY_END_X_DEF;
            end
            default: begin
               area_full = 1'b1;
            end
         endcase
         case ($urandom_range(3))
            0, 1: idle_pct = 0;
            2: idle_pct = 15;
            default: idle_pct = 40;
         endcase

         // new vertices, with a few queries against the setting still in force
         for (int s = 0; s < m; s++) begin
            send_item(KIND_VERTEX, INDEX_W'(s), area_coord(area_cx), area_coord(area_cy),
                      1'b0, 1'b0);
            if ($urandom_range(99) < 12) begin
               pt = query_point(s + 1);
               send_item(KIND_QUERY, INDEX_W'($urandom_range(63)), pt.x, pt.y, 1'b0, 1'b0);
            end
         end
         set_vertex_count(COUNT_W'(n_next));

         nq = $urandom_range(30, 8);
         for (int q = 0; q < nq; q++) begin
            if ($urandom_range(99) < 10) begin
               send_item(KIND_VERTEX, INDEX_W'($urandom_range(63)), area_coord(area_cx),
                         area_coord(area_cy), 1'b0, 1'b0);
            end else begin
               pt = query_point(m);
               send_item(KIND_QUERY, INDEX_W'($urandom_range(63)), pt.x, pt.y, 1'b0, 1'b0);
            end
         end
         phase_no++;
      end

      // let the last results come in and catch any stray ones
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
